// ----- src/ple_pkg.sv -----
// Package with the operation, status and cell command types of the positional list engine.
package ple_pkg;

    localparam int DATA_W = 32;
    localparam int LEN_W  = 7;

    typedef enum logic [2:0] {
        OP_PUSH_HEAD = 3'd0,
        OP_PUSH_TAIL = 3'd1,
        OP_POP_HEAD  = 3'd2,
        OP_POP_TAIL  = 3'd3,
        OP_INSERT_AT = 3'd4,
        OP_REMOVE_AT = 3'd5,
        OP_DUMP      = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CK_HOLD   = 2'd0,
        CK_INSERT = 2'd1,
        CK_REMOVE = 2'd2,
        CK_ROTATE = 2'd3
    } cell_kind_t;

    typedef struct packed {
        cell_kind_t               kind;
        logic [LEN_W-1:0]         pos;
        logic [LEN_W-1:0]         cnt;
        logic signed [DATA_W-1:0] value;
    } cell_cmd_t;

endpackage

// ----- src/positional_list_engine_top.sv -----
// Top level of the positional list engine: command decode, cell chain and result register.
//
// The list lives in a chain of CAPACITY cells, front at cell 0, and every edit (push, pop,
// insert, remove) shifts all cells behind the edit point in the same cycle, so for an edit
// or a rejected command the single status transaction is registered at once. A dump starts
// up when it is accepted and then, while the result register is free, rotates the chain one
// place per cycle, reading cell 0; it yields one element transaction per stored element (a
// single status transaction for an empty list) and leaves the list as it was. The result
// register frees as soon as the consumer takes a transaction, so back-pressure on the
// result channel stalls the input channel and the dump.
module positional_list_engine_top
    import ple_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [2:0]               s_operation,
    input  logic signed [DATA_W-1:0] s_value,
    input  logic signed [15:0]       s_position,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [1:0]               m_status,
    output logic signed [DATA_W-1:0] m_element,
    output logic                     m_element_valid,
    output logic [LEN_W-1:0]         m_length,
    output logic                     m_last
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = $clog2(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DUMP = 2'b10
    } state_t;

    state_t                   state_reg;
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic [KW-1:0]            dump_idx_reg;
    logic                     m_valid_reg;
    logic [1:0]               m_status_reg;
    logic signed [DATA_W-1:0] m_element_reg;
    logic                     m_element_valid_reg;
    logic [LEN_W-1:0]         m_length_reg;
    logic                     m_last_reg;

    logic                     out_free;
    logic                     s_accept;
    logic                     full;
    logic                     empty;
    logic [LEN_W-1:0]         cnt7;
    logic [14:0]              pos_mag;
    logic [14:0]              cnt15;
    logic                     pos_neg;
    status_t                  status;
    logic                     start_dump;
    logic                     dump_step;
    logic                     dump_last;
    logic                     result_load;
    cell_cmd_t                cmd;

    logic signed [DATA_W-1:0] cell_data [CAPACITY];

    assign out_free    = !m_valid_reg || m_ready;
    assign s_ready     = (state_reg == S_IDLE) && out_free;
    assign s_accept    = s_valid && s_ready;
    assign full        = count_reg == CW'(CAPACITY);
    assign empty       = count_reg == '0;
    assign cnt7        = LEN_W'(count_reg);
    assign pos_mag     = s_position[14:0];
    assign pos_neg     = s_position[15];
    assign cnt15       = 15'(count_reg);
    assign dump_step   = (state_reg == S_DUMP) && out_free;
    assign dump_last   = (CW'(dump_idx_reg) + CW'(1)) == count_reg;
    assign result_load = (s_accept && !(start_dump && !empty)) || dump_step;

    always_comb begin
        cmd        = '{kind: CK_HOLD, pos: '0, cnt: cnt7, value: s_value};
        status     = ST_OK;
        count_next = count_reg;
        start_dump = 1'b0;
        case (s_operation)
            OP_PUSH_HEAD, OP_PUSH_TAIL: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    cmd.kind   = CK_INSERT;
                    cmd.pos    = (s_operation == OP_PUSH_HEAD) ? '0 : cnt7;
                    count_next = count_reg + CW'(1);
                end
            end
            OP_POP_HEAD, OP_POP_TAIL: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    cmd.kind   = CK_REMOVE;
                    cmd.pos    = (s_operation == OP_POP_HEAD) ? '0 : cnt7 - LEN_W'(1);
                    count_next = count_reg - CW'(1);
                end
            end
            OP_INSERT_AT: begin
                if (pos_neg || pos_mag > cnt15) begin
                    status = ST_INVALID;
                end else if (full) begin
                    status = ST_FULL;
                end else begin
                    cmd.kind   = CK_INSERT;
                    cmd.pos    = pos_mag[LEN_W-1:0];
                    count_next = count_reg + CW'(1);
                end
            end
            OP_REMOVE_AT: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else if (pos_neg || pos_mag >= cnt15) begin
                    status = ST_INVALID;
                end else begin
                    cmd.kind   = CK_REMOVE;
                    cmd.pos    = pos_mag[LEN_W-1:0];
                    count_next = count_reg - CW'(1);
                end
            end
            OP_DUMP: begin
                start_dump = 1'b1;
            end
            default: begin
                status = ST_INVALID;
            end
        endcase
        if (!s_accept) begin
            cmd.kind = CK_HOLD;
        end
        if (dump_step) begin
            cmd.kind = CK_ROTATE;
        end
    end

    generate
        for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
            logic signed [DATA_W-1:0] left_d;
            logic signed [DATA_W-1:0] right_d;
            if (g == 0) begin : g_first
                assign left_d = s_value;
            end else begin : g_mid_l
                assign left_d = cell_data[g-1];
            end
            if (g == CAPACITY - 1) begin : g_final
                assign right_d = cell_data[0];
            end else begin : g_mid_r
                assign right_d = cell_data[g+1];
            end
            ple_cell #(
                .IDX (g)
            ) u_cell (
                .aclk       (aclk),
                .cmd        (cmd),
                .left_data  (left_d),
                .right_data (right_d),
                .wrap_data  (cell_data[0]),
                .data       (cell_data[g])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            dump_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && !result_load) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        count_reg <= count_next;
                        if (start_dump && !empty) begin
                            state_reg    <= S_DUMP;
                            dump_idx_reg <= '0;
                        end else begin
                            m_valid_reg         <= 1'b1;
                            m_status_reg        <= status;
                            m_element_reg       <= '0;
                            m_element_valid_reg <= 1'b0;
                            m_length_reg        <= LEN_W'(count_next);
                            m_last_reg          <= 1'b1;
                        end
                    end
                end
                S_DUMP: begin
                    if (dump_step) begin
                        m_valid_reg         <= 1'b1;
                        m_status_reg        <= ST_OK;
                        m_element_reg       <= cell_data[0];
                        m_element_valid_reg <= 1'b1;
                        m_length_reg        <= cnt7;
                        m_last_reg          <= dump_last;
                        dump_idx_reg        <= dump_idx_reg + KW'(1);
                        if (dump_last) begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_element       = m_element_reg;
    assign m_element_valid = m_element_valid_reg;
    assign m_length        = m_length_reg;
    assign m_last          = m_last_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("The entry count exceeds the capacity.");

    a_dump_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DUMP |=> count_reg == $past(count_reg))
        else $error("The entry count changed during a dump.");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (count_reg == $past(count_reg)
                      || count_reg == $past(count_reg) + CW'(1)
                      || count_reg == $past(count_reg) - CW'(1)))
        else $error("One transaction changed the entry count by more than one.");

    a_status_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_element_valid |-> m_last)
        else $error("A status transaction was not marked as last.");

endmodule

// ----- src/ple_cell.sv -----
// Storage cell of the list chain; on command it loads or shifts from either side.
module ple_cell
    import ple_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic                     aclk,
    input  cell_cmd_t                cmd,
    input  logic signed [DATA_W-1:0] left_data,
    input  logic signed [DATA_W-1:0] right_data,
    input  logic signed [DATA_W-1:0] wrap_data,
    output logic signed [DATA_W-1:0] data
);

    localparam logic [LEN_W-1:0] IDX_L = LEN_W'(IDX);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        case (cmd.kind)
            CK_INSERT: begin
                if (IDX_L == cmd.pos) begin
                    data_next = cmd.value;
                end else if (IDX_L > cmd.pos) begin
                    data_next = left_data;
                end
            end
            CK_REMOVE: begin
                if (IDX_L >= cmd.pos) begin
                    data_next = right_data;
                end
            end
            CK_ROTATE: begin
                if (IDX_L == cmd.cnt - LEN_W'(1)) begin
                    data_next = wrap_data;
                end else begin
                    data_next = right_data;
                end
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ----- dv/ple_checker.sv -----
// Checker for the positional list engine: predicts every result transaction and compares it.
`timescale 1ns / 1ps

module ple_checker
    import ple_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic [2:0]               s_operation,
    input  logic signed [DATA_W-1:0] s_value,
    input  logic signed [15:0]       s_position,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic [1:0]               m_status,
    input  logic signed [DATA_W-1:0] m_element,
    input  logic                     m_element_valid,
    input  logic [LEN_W-1:0]         m_length,
    input  logic                     m_last,
    output int                       fail_count,
    output int                       outstanding
);

    typedef struct {
        status_t                  status;
        logic signed [DATA_W-1:0] element;
        logic                     element_valid;
        logic [LEN_W-1:0]         length;
        logic                     last;
    } list_result_t;

    list_result_t             awaited_results[$];
    logic signed [DATA_W-1:0] list_cells [CAPACITY];
    int                       entries;

    function automatic list_result_t status_result(status_t st);
        list_result_t r;
        r.status        = st;
        r.element       = '0;
        r.element_valid = 1'b0;
        r.length        = LEN_W'(entries);
        r.last          = 1'b1;
        return r;
    endfunction

    task automatic open_gap(int p, logic signed [DATA_W-1:0] v);
        for (int i = entries; i > p; i--) begin
            list_cells[i] = list_cells[i-1];
        end
        list_cells[p] = v;
        entries++;
    endtask

    task automatic close_gap(int p);
        for (int i = p; i + 1 < entries; i++) begin
            list_cells[i] = list_cells[i+1];
        end
        entries--;
    endtask

    task automatic predict_list_op(logic [2:0] op, logic signed [DATA_W-1:0] val,
                                   logic signed [15:0] pos);
        status_t      st;
        list_result_t r;
        int           p;
        st = ST_OK;
        p  = pos;
        case (op)
            OP_PUSH_HEAD, OP_PUSH_TAIL: begin
                if (entries >= CAPACITY) st = ST_FULL;
                else open_gap((op == OP_PUSH_HEAD) ? 0 : entries, val);
            end
            OP_POP_HEAD, OP_POP_TAIL: begin
                if (entries == 0) st = ST_EMPTY;
                else close_gap((op == OP_POP_HEAD) ? 0 : entries - 1);
            end
            OP_INSERT_AT: begin
                if (p < 0 || p > entries) st = ST_INVALID;
                else if (entries >= CAPACITY) st = ST_FULL;
                else open_gap(p, val);
            end
            OP_REMOVE_AT: begin
                if (entries == 0) st = ST_EMPTY;
                else if (p < 0 || p >= entries) st = ST_INVALID;
                else close_gap(p);
            end
            OP_DUMP: begin
                if (entries == 0) begin
                    awaited_results.insert(awaited_results.size(), status_result(ST_OK));
                end else begin
                    for (int i = 0; i < entries; i++) begin
                        r.status        = ST_OK;
                        r.element       = list_cells[i];
                        r.element_valid = 1'b1;
                        r.length        = LEN_W'(entries);
                        r.last          = (i == entries - 1);
                        awaited_results.insert(awaited_results.size(), r);
                    end
                end
                return;
            end
            default: st = ST_INVALID;
        endcase
        awaited_results.insert(awaited_results.size(), status_result(st));
    endtask

    always @(posedge aclk) begin : monitor
        list_result_t want;
        if (!aresetn) begin
            entries = 0;
            awaited_results.delete();
        end else begin
            if (s_valid && s_ready) begin
                predict_list_op(s_operation, s_value, s_position);
            end
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("mismatch: result transaction with nothing awaited, status %0d",
                                 m_status);
                    end
                end else begin
                    want = awaited_results[0];
                    awaited_results.delete(0);
                    if (m_status !== want.status || m_element !== want.element ||
                        m_element_valid !== want.element_valid ||
                        m_length !== want.length || m_last !== want.last) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display({"mismatch: expected status %0d element %0d valid %0d",
                                      " length %0d last %0d"},
                                     want.status, want.element, want.element_valid,
                                     want.length, want.last);
                            $display({"          actual   status %0d element %0d valid %0d",
                                      " length %0d last %0d"},
                                     m_status, m_element, m_element_valid,
                                     m_length, m_last);
                        end
                    end
                end
            end
        end
        outstanding <= awaited_results.size();
    end

endmodule

// ----- dv/tb_top.sv -----
// Testbench top for the positional list engine: clock, reset, stimulus, receiver and verdict.
`timescale 1ns / 1ps

module tb_top;
    import ple_pkg::*;

    localparam int          LIST_CAP    = 16;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          HOLD_CYCLES = 400;
    localparam int          RANDOM_OPS  = 440;
    localparam logic [2:0]  OP_RESERVED = 3'd7;

    typedef enum int {RX_OPEN, RX_HALF, RX_MOSTLY, RX_SPARSE, RX_CADENCE} rx_mode_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [2:0]               s_operation;
    logic signed [DATA_W-1:0] s_value;
    logic signed [15:0]       s_position;
    logic                     m_valid;
    logic                     m_ready;
    logic [1:0]               m_status;
    logic signed [DATA_W-1:0] m_element;
    logic                     m_element_valid;
    logic [LEN_W-1:0]         m_length;
    logic                     m_last;
    int                       fail_count;
    int                       outstanding;

    logic hold_off_req  = 1'b0;
    logic hold_off_done = 1'b0;
    int   stim_len      = 0;
    int   burst_left    = 0;

    positional_list_engine_top #(.CAPACITY(LIST_CAP)) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_value         (s_value),
        .s_position      (s_position),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_element       (m_element),
        .m_element_valid (m_element_valid),
        .m_length        (m_length),
        .m_last          (m_last)
    );

    ple_checker #(.CAPACITY(LIST_CAP)) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_value         (s_value),
        .s_position      (s_position),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_element       (m_element),
        .m_element_valid (m_element_valid),
        .m_length        (m_length),
        .m_last          (m_last),
        .fail_count      (fail_count),
        .outstanding     (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    initial begin : receiver
        rx_mode_t mode;
        int       span;
        int       tick;
        mode = RX_OPEN;
        span = 0;
        tick = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_req && !hold_off_done) begin
                hold_off_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            if (span == 0) begin
                mode = rx_mode_t'($urandom_range(0, 4));
                span = $urandom_range(16, 96);
            end
            span--;
            tick++;
            case (mode)
                RX_OPEN:   m_ready <= 1'b1;
                RX_HALF:   m_ready <= ($urandom_range(0, 1) == 1);
                RX_MOSTLY: m_ready <= ($urandom_range(0, 3) != 0);
                RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                default:   m_ready <= (tick % 3 == 0);
            endcase
        end
    end

    task automatic send_item(logic [2:0] op, logic signed [DATA_W-1:0] val,
                             logic signed [15:0] pos);
        int gap;
        s_valid     <= 1'b1;
        s_operation <= op;
        s_value     <= val;
        s_position  <= pos;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        // Track the length only to steer positions toward the interesting range.
        case (op)
            OP_PUSH_HEAD, OP_PUSH_TAIL: if (stim_len < LIST_CAP) stim_len++;
            OP_POP_HEAD, OP_POP_TAIL:   if (stim_len > 0) stim_len--;
            OP_INSERT_AT: begin
                if (pos >= 0 && pos <= stim_len && stim_len < LIST_CAP) stim_len++;
            end
            OP_REMOVE_AT: if (stim_len > 0 && pos >= 0 && pos < stim_len) stim_len--;
            default: ;
        endcase
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap        = $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(0, 12);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    initial begin : stimulus
        logic [2:0]               op;
        logic signed [DATA_W-1:0] val;
        logic signed [15:0]       pos;
        int                       pick;
        int                       phase;
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_operation <= OP_PUSH_HEAD;
        s_value     <= '0;
        s_position  <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_item(OP_DUMP,       32'sd0, 16'sd0);
        send_item(OP_POP_HEAD,   32'sd0, 16'sd0);
        send_item(OP_POP_TAIL,   32'sd0, 16'sd0);
        send_item(OP_REMOVE_AT,  32'sd0, 16'sd0);
        send_item(OP_REMOVE_AT,  32'sd0, 16'sh8000);
        send_item(OP_INSERT_AT,  32'sd7, 16'sd1);
        send_item(OP_INSERT_AT,  32'sd7, -16'sd1);
        send_item(OP_INSERT_AT,  32'sh8000_0000, 16'sd0);
        send_item(OP_PUSH_HEAD,  32'sh7FFF_FFFF, 16'sd0);
        send_item(OP_PUSH_TAIL,  -32'sd1, 16'sd0);
        send_item(OP_INSERT_AT,  32'sh0000_1234, 16'sd3);
        send_item(OP_INSERT_AT,  32'sh5555_AAAA, 16'sd2);
        send_item(OP_INSERT_AT,  32'sd9, 16'sh7FFF);
        send_item(OP_REMOVE_AT,  32'sd0, 16'sh8000);
        send_item(OP_REMOVE_AT,  32'sd0, 16'sd5);
        send_item(OP_DUMP,       32'sd0, 16'sd0);
        send_item(OP_REMOVE_AT,  32'sd0, 16'sd1);
        send_item(OP_REMOVE_AT,  32'sd0, 16'sd3);
        send_item(OP_POP_HEAD,   32'sd0, 16'sd0);
        send_item(OP_POP_TAIL,   32'sd0, 16'sd0);
        send_item(OP_RESERVED,   32'sd0, 16'sd0);
        send_item(OP_DUMP,       32'sd0, 16'sd0);
        send_item(OP_PUSH_TAIL,  32'sd0, 16'sd0);

        // Phases alternate between growing, shrinking and mixed traffic so that
        // both the full and the empty corners are reached many times.
        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (n == 100) hold_off_req = 1'b1;
            phase = (n / 40) % 3;
            pick  = $urandom_range(0, 99);
            if (phase == 0) begin
                if (pick < 25)      op = OP_PUSH_HEAD;
                else if (pick < 50) op = OP_PUSH_TAIL;
                else if (pick < 75) op = OP_INSERT_AT;
                else if (pick < 85) op = OP_DUMP;
                else if (pick < 90) op = OP_POP_HEAD;
                else if (pick < 95) op = OP_REMOVE_AT;
                else                op = 3'($urandom_range(0, 7));
            end else if (phase == 1) begin
                if (pick < 20)      op = OP_POP_HEAD;
                else if (pick < 40) op = OP_POP_TAIL;
                else if (pick < 70) op = OP_REMOVE_AT;
                else if (pick < 80) op = OP_DUMP;
                else if (pick < 90) op = ($urandom_range(0, 1) == 1) ? OP_PUSH_TAIL
                                                                      : OP_INSERT_AT;
                else                op = 3'($urandom_range(0, 7));
            end else begin
                op = 3'($urandom_range(0, 7));
            end

            pick = $urandom_range(0, 9);
            if (pick == 0)      val = 32'sh8000_0000;
            else if (pick == 1) val = 32'sh7FFF_FFFF;
            else if (pick == 2) val = ($urandom_range(0, 1) == 1) ? -32'sd1 : 32'sd0;
            else                val = $urandom();

            pick = $urandom_range(0, 99);
            if (op == OP_INSERT_AT && pick < 75) begin
                pos = 16'($urandom_range(0, stim_len));
            end else if (op == OP_REMOVE_AT && pick < 75) begin
                pos = (stim_len > 0) ? 16'($urandom_range(0, stim_len - 1)) : 16'sd0;
            end else if (pick < 83) begin
                pos = 16'(stim_len + $urandom_range(0, 3));
            end else if (pick < 91) begin
                pos = 16'(-$urandom_range(1, 4));
            end else begin
                pos = 16'($urandom());
            end

            send_item(op, val, pos);
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
